// ===== rtl/lr4_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and step program for the LR4 crossover block.
// Used by lr4_cfg_regs, lr4_ctrl, lr4_datapath and the top level; no dependencies.

package lr4_pkg;

  // field and arithmetic widths
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int STATE_BITS  = 48;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int COEF_FRAC   = COEF_BITS - 4;
  localparam int FRAC        = (STATE_BITS - SAMPLE_BITS > 8) ?
                               (STATE_BITS - SAMPLE_BITS - 8) : 0;
  localparam int OUT_SHIFT   = FRAC + GAIN_FRAC;

  // coefficient operand is one bit wider so that negated values fit
  localparam int CMUL_BITS = COEF_BITS + 1;
  // state operand split into two halves for the partial products
  localparam int LO_BITS   = STATE_BITS / 2;
  localparam int HI_BITS   = STATE_BITS - LO_BITS;
  localparam int PL_BITS   = CMUL_BITS + LO_BITS + 1;
  localparam int PH_BITS   = CMUL_BITS + HI_BITS;
  localparam int PROD_BITS = CMUL_BITS + STATE_BITS;

  // stream and register port widths
  localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS = COEF_BITS;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);

  // rounding offsets, half an lsb of the result
  localparam logic signed [PROD_BITS-1:0] RND_COEF =
    {{(PROD_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
  localparam logic signed [PROD_BITS-1:0] RND_OUT =
    {{(PROD_BITS-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);

  // saturation limits
  localparam logic signed [STATE_BITS-1:0]  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0]  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // multiply pipeline depth, issue to accumulator write
  localparam int PIPE_STAGES = 4;
  localparam int DRAIN_BITS  = $clog2(PIPE_STAGES);
  localparam logic [DRAIN_BITS-1:0] DRAIN_LAST = DRAIN_BITS'(PIPE_STAGES - 2);

  // program addresses
  localparam int PC_BITS = 5;
  localparam logic [PC_BITS-1:0] PC_FILT_FIRST = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] PC_FILT_LAST  = PC_BITS'(16);
  localparam logic [PC_BITS-1:0] PC_BYPASS     = PC_BITS'(17);
  localparam logic [PC_BITS-1:0] PC_MUTE       = PC_BITS'(18);

  // register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_GAIN, REG_EN
  } cfg_idx_t;

  typedef enum logic [1:0] {OPND_X, OPND_Y, OPND_Z} opnd_t;

  typedef enum logic [2:0] {C_B0, C_B1, C_B2, C_NA1, C_NA2, C_GAIN} coef_sel_t;

  typedef enum logic [2:0] {
    SRC_PROD, SRC_D1A, SRC_D2A, SRC_D1B, SRC_D2B, SRC_ZERO
  } term_src_t;

  typedef enum logic [2:0] {
    DST_Y, DST_D1A, DST_D2A, DST_Z, DST_D1B, DST_D2B, DST_OUT
  } dest_t;

  typedef enum logic {ACC_LOAD, ACC_ADD} acc_mode_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_HOLD} fsm_state_t;

  // one step of the sequencer
  typedef struct packed {
    logic      valid;
    opnd_t     opnd;
    coef_sel_t coef;
    term_src_t src;
    dest_t     dest;
    acc_mode_t mode;
  } op_t;

  localparam op_t OP_NOP = '{1'b0, OPND_X, C_B0, SRC_ZERO, DST_Y, ACC_LOAD};

  // controller to datapath
  typedef struct packed {
    logic load_x;
    logic out_load;
    op_t  op;
  } dp_cmd_t;

  // coefficient set, feedback terms stored negated
  typedef struct packed {
    logic signed [CMUL_BITS-1:0] b0;
    logic signed [CMUL_BITS-1:0] b1;
    logic signed [CMUL_BITS-1:0] b2;
    logic signed [CMUL_BITS-1:0] na1;
    logic signed [CMUL_BITS-1:0] na2;
    logic        [GAIN_BITS-1:0] gain;
  } coef_set_t;

  typedef struct packed {
    logic mute;
    logic filt_en;
  } cfg_status_t;

  // step program: both biquads, then bypass and mute
  function automatic op_t prog_op(input logic [PC_BITS-1:0] pc);
    op_t op;
    op = OP_NOP;
    unique case (pc)
      5'd0:  op = '{1'b1, OPND_X, C_B0,   SRC_PROD, DST_Y,   ACC_LOAD};
      5'd1:  op = '{1'b1, OPND_X, C_B0,   SRC_D1A,  DST_Y,   ACC_ADD};
      5'd2:  op = '{1'b1, OPND_X, C_B1,   SRC_PROD, DST_D1A, ACC_LOAD};
      5'd5:  op = '{1'b1, OPND_Y, C_B0,   SRC_PROD, DST_Z,   ACC_LOAD};
      5'd6:  op = '{1'b1, OPND_Y, C_B0,   SRC_D1B,  DST_Z,   ACC_ADD};
      5'd7:  op = '{1'b1, OPND_Y, C_NA1,  SRC_PROD, DST_D1A, ACC_ADD};
      5'd8:  op = '{1'b1, OPND_Y, C_NA1,  SRC_D2A,  DST_D1A, ACC_ADD};
      5'd9:  op = '{1'b1, OPND_X, C_B2,   SRC_PROD, DST_D2A, ACC_LOAD};
      5'd10: op = '{1'b1, OPND_Z, C_GAIN, SRC_PROD, DST_OUT, ACC_LOAD};
      5'd11: op = '{1'b1, OPND_Y, C_NA2,  SRC_PROD, DST_D2A, ACC_ADD};
      5'd12: op = '{1'b1, OPND_Y, C_B1,   SRC_PROD, DST_D1B, ACC_LOAD};
      5'd13: op = '{1'b1, OPND_Z, C_NA1,  SRC_PROD, DST_D1B, ACC_ADD};
      5'd14: op = '{1'b1, OPND_Z, C_NA1,  SRC_D2B,  DST_D1B, ACC_ADD};
      5'd15: op = '{1'b1, OPND_Y, C_B2,   SRC_PROD, DST_D2B, ACC_LOAD};
      5'd16: op = '{1'b1, OPND_Z, C_NA2,  SRC_PROD, DST_D2B, ACC_ADD};
      5'd17: op = '{1'b1, OPND_X, C_GAIN, SRC_PROD, DST_OUT, ACC_LOAD};
      5'd18: op = '{1'b1, OPND_X, C_GAIN, SRC_ZERO, DST_OUT, ACC_LOAD};
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/lr4_crossover_filter.sv =====
`timescale 1ns / 1ps
// Fourth-order Linkwitz-Riley crossover section, top level.
// Depends on lr4_pkg, lr4_cfg_regs, lr4_ctrl and lr4_datapath.

// Each 24-bit sample runs through two cascaded biquads sharing one coefficient
// set, then through the gain, rounded and saturated to 24 bits. All products go
// through one split multiplier pipeline four stages deep, fed one step a cycle
// by a 17-step program; with the filter disabled or a zero gain the program is
// a single step. A new sample is taken only after the last one has left the
// pipeline. The finished result sits in an output register, so the next sample
// is taken while it waits. Configuration writes to known registers take effect
// at once, clear the filter state, and belong between samples.

module lr4_crossover_filter import lr4_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input samples
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [TDATA_BITS-1:0]    in_tdata,   // [23:0] sample_in
  // results
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TDATA_BITS-1:0]    out_tdata,  // [23:0] sample_out
  // register writes
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  coef_set_t               coefs;
  cfg_status_t             cfg_st;
  dp_cmd_t                 cmd;
  logic                    state_clr;
  logic [SAMPLE_BITS-1:0]  out_sample;

  // configuration registers
  lr4_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs),
    .cfg_st    (cfg_st),
    .state_clr (state_clr)
  );

  // sequencer
  lr4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_st     (cfg_st),
    .cmd        (cmd)
  );

  // arithmetic
  lr4_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_sample  ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .coefs      (coefs),
    .state_clr  (state_clr),
    .out_sample (out_sample)
  );

  assign out_tdata = TDATA_BITS'(out_sample);

endmodule

// ===== rtl/lr4_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file: coefficients, gain and filter enable.
// Depends on lr4_pkg; raises a state clear on every write to a known register.

module lr4_cfg_regs import lr4_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output coef_set_t                coefs,
  output cfg_status_t              cfg_st,
  output logic                     state_clr
);

  coef_set_t coef_r, coef_nxt;
  logic      en_r, en_nxt;
  logic signed [CMUL_BITS-1:0] wcoef;

  // register writes, feedback coefficients kept negated
  always_comb begin
    coef_nxt  = coef_r;
    en_nxt    = en_r;
    state_clr = 1'b0;
    wcoef     = CMUL_BITS'($signed(cfg_wdata[COEF_BITS-1:0]));
    if (cfg_we) begin
      state_clr = 1'b1;
      unique case (cfg_idx_t'(cfg_addr))
        REG_B0:   coef_nxt.b0   = wcoef;
        REG_B1:   coef_nxt.b1   = wcoef;
        REG_B2:   coef_nxt.b2   = wcoef;
        REG_A1:   coef_nxt.na1  = -wcoef;
        REG_A2:   coef_nxt.na2  = -wcoef;
        REG_GAIN: coef_nxt.gain = cfg_wdata[GAIN_BITS-1:0];
        REG_EN:   en_nxt        = cfg_wdata[0];
        default:  state_clr     = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{b0: '0, b1: '0, b2: '0, na1: '0, na2: '0, gain: GAIN_UNITY};
      en_r   <= 1'b0;
    end else begin
      coef_r <= coef_nxt;
      en_r   <= en_nxt;
    end
  end

  assign coefs          = coef_r;
  assign cfg_st.mute    = (coef_r.gain == '0);
  assign cfg_st.filt_en = en_r;

endmodule

// ===== rtl/lr4_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: shared split multiplier pipeline, rounding, saturation and accumulators.
// Depends on lr4_pkg; driven step by step by lr4_ctrl.

module lr4_datapath import lr4_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  coef_set_t                     coefs,
  input  logic                          state_clr,
  output logic        [SAMPLE_BITS-1:0] out_sample
);

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [PROD_BITS-1:0] v
  );
    logic [PROD_BITS-STATE_BITS:0] top;
    logic signed [STATE_BITS-1:0]  r;
    top = v[PROD_BITS-1:STATE_BITS-1];
    if ((&top) || !(|top)) r = v[STATE_BITS-1:0];
    else if (v[PROD_BITS-1]) r = STATE_MIN;
    else r = STATE_MAX;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [PROD_BITS-1:0] v
  );
    logic [PROD_BITS-SAMPLE_BITS:0] top;
    logic signed [SAMPLE_BITS-1:0]  r;
    top = v[PROD_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) r = v[SAMPLE_BITS-1:0];
    else if (v[PROD_BITS-1]) r = SAMPLE_MIN;
    else r = SAMPLE_MAX;
    return r;
  endfunction

  // operand and state registers
  logic signed [STATE_BITS-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [STATE_BITS-1:0] d1a_r, d1a_nxt, d2a_r, d2a_nxt;
  logic signed [STATE_BITS-1:0] d1b_r, d1b_nxt, d2b_r, d2b_nxt;
  logic        [SAMPLE_BITS-1:0] res_r, res_nxt, out_data_r, out_data_nxt;

  // pipeline registers
  op_t s1_op_r, s2_op_r, s3_op_r;
  logic signed [PL_BITS-1:0]    s1_pl_r, s1_pl_nxt;
  logic signed [PH_BITS-1:0]    s1_ph_r, s1_ph_nxt;
  logic signed [PROD_BITS-1:0]  s2_sum_r, s2_sum_nxt;
  logic signed [STATE_BITS-1:0] s3_term_r, s3_term_nxt;

  logic signed [STATE_BITS-1:0] opa;
  logic signed [CMUL_BITS-1:0]  opc;
  logic signed [PROD_BITS-1:0]  ph_ext, pl_ext, rnd, shifted;
  logic signed [STATE_BITS-1:0] term, acc, acc_sat, new_val;
  logic signed [STATE_BITS:0]   acc_sum;

  // stage 1: operand select and the two partial products
  always_comb begin
    unique case (cmd.op.opnd)
      OPND_X:  opa = x_r;
      OPND_Y:  opa = y_r;
      OPND_Z:  opa = z_r;
      default: opa = '0;
    endcase
    unique case (cmd.op.coef)
      C_B0:    opc = coefs.b0;
      C_B1:    opc = coefs.b1;
      C_B2:    opc = coefs.b2;
      C_NA1:   opc = coefs.na1;
      C_NA2:   opc = coefs.na2;
      C_GAIN:  opc = $signed(CMUL_BITS'(coefs.gain));
      default: opc = '0;
    endcase
    s1_pl_nxt = opc * $signed({1'b0, opa[LO_BITS-1:0]});
    s1_ph_nxt = opc * $signed(opa[STATE_BITS-1:LO_BITS]);
  end

  // stage 2: combine halves and add the rounding offset
  always_comb begin
    ph_ext     = PROD_BITS'(s1_ph_r);
    pl_ext     = PROD_BITS'(s1_pl_r);
    rnd        = (s1_op_r.dest == DST_OUT) ? RND_OUT : RND_COEF;
    s2_sum_nxt = (ph_ext <<< LO_BITS) + pl_ext + rnd;
  end

  // stage 3: scale down and saturate to state or sample range
  always_comb begin
    if (s2_op_r.dest == DST_OUT) begin
      shifted     = s2_sum_r >>> OUT_SHIFT;
      s3_term_nxt = STATE_BITS'(sat_sample(shifted));
    end else begin
      shifted     = s2_sum_r >>> COEF_FRAC;
      s3_term_nxt = sat_state(shifted);
    end
  end

  // stage 4: saturating accumulate into the destination
  always_comb begin
    unique case (s3_op_r.src)
      SRC_PROD: term = s3_term_r;
      SRC_D1A:  term = d1a_r;
      SRC_D2A:  term = d2a_r;
      SRC_D1B:  term = d1b_r;
      SRC_D2B:  term = d2b_r;
      SRC_ZERO: term = '0;
      default:  term = '0;
    endcase
    unique case (s3_op_r.dest)
      DST_Y:   acc = y_r;
      DST_D1A: acc = d1a_r;
      DST_D2A: acc = d2a_r;
      DST_Z:   acc = z_r;
      DST_D1B: acc = d1b_r;
      DST_D2B: acc = d2b_r;
      default: acc = '0;
    endcase
    acc_sum = {acc[STATE_BITS-1], acc} + {term[STATE_BITS-1], term};
    if (acc_sum[STATE_BITS] != acc_sum[STATE_BITS-1])
      acc_sat = acc_sum[STATE_BITS] ? STATE_MIN : STATE_MAX;
    else
      acc_sat = acc_sum[STATE_BITS-1:0];
    new_val = (s3_op_r.mode == ACC_LOAD) ? term : acc_sat;

    y_nxt   = y_r;
    z_nxt   = z_r;
    d1a_nxt = d1a_r;
    d2a_nxt = d2a_r;
    d1b_nxt = d1b_r;
    d2b_nxt = d2b_r;
    res_nxt = res_r;
    if (s3_op_r.valid) begin
      unique case (s3_op_r.dest)
        DST_Y:   y_nxt   = new_val;
        DST_D1A: d1a_nxt = new_val;
        DST_D2A: d2a_nxt = new_val;
        DST_Z:   z_nxt   = new_val;
        DST_D1B: d1b_nxt = new_val;
        DST_D2B: d2b_nxt = new_val;
        DST_OUT: res_nxt = term[SAMPLE_BITS-1:0];
        default: res_nxt = res_r;
      endcase
    end
    if (state_clr) begin
      d1a_nxt = '0;
      d2a_nxt = '0;
      d1b_nxt = '0;
      d2b_nxt = '0;
    end
  end

  // input widening and output holding register
  always_comb begin
    x_nxt        = cmd.load_x ? (STATE_BITS'(in_sample) <<< FRAC) : x_r;
    out_data_nxt = cmd.out_load ? res_r : out_data_r;
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_op_r <= OP_NOP;
      s2_op_r <= OP_NOP;
      s3_op_r <= OP_NOP;
      d1a_r   <= '0;
      d2a_r   <= '0;
      d1b_r   <= '0;
      d2b_r   <= '0;
    end else begin
      s1_op_r <= cmd.op;
      s2_op_r <= s1_op_r;
      s3_op_r <= s2_op_r;
      d1a_r   <= d1a_nxt;
      d2a_r   <= d2a_nxt;
      d1b_r   <= d1b_nxt;
      d2b_r   <= d2b_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_pl_r    <= s1_pl_nxt;
    s1_ph_r    <= s1_ph_nxt;
    s2_sum_r   <= s2_sum_nxt;
    s3_term_r  <= s3_term_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_sample = out_data_r;

endmodule

// ===== rtl/lr4_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: stream handshakes and the step sequencer that drives the datapath.
// Depends on lr4_pkg (state type, step program, command struct).

module lr4_ctrl import lr4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  cfg_status_t cfg_st,
  output dp_cmd_t     cmd
);

  fsm_state_t state_r, state_nxt;
  logic [PC_BITS-1:0]    pc_r, pc_nxt, last_r, last_nxt;
  logic [DRAIN_BITS-1:0] drain_r, drain_nxt;
  logic                  out_vld_r, out_vld_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    last_nxt     = last_r;
    drain_nxt    = drain_r;
    out_vld_nxt  = out_vld_r;
    in_tready    = 1'b0;
    cmd.load_x   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.op       = OP_NOP;
    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_ISSUE;
          priority if (cfg_st.mute) begin
            pc_nxt   = PC_MUTE;
            last_nxt = PC_MUTE;
          end else if (cfg_st.filt_en) begin
            pc_nxt   = PC_FILT_FIRST;
            last_nxt = PC_FILT_LAST;
          end else begin
            pc_nxt   = PC_BYPASS;
            last_nxt = PC_BYPASS;
          end
        end
      end
      ST_ISSUE: begin
        cmd.op = prog_op(pc_r);
        if (pc_r == last_r) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          pc_nxt = pc_r + PC_BITS'(1);
        end
      end
      // wait for the last step to leave the multiply pipeline
      ST_DRAIN: begin
        if (drain_r == DRAIN_LAST) state_nxt = ST_HOLD;
        else drain_nxt = drain_r + DRAIN_BITS'(1);
      end
      ST_HOLD: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pc_r      <= '0;
      last_r    <= '0;
      drain_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      last_r    <= last_nxt;
      drain_r   <= drain_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== tb/tb_lr4_crossover_filter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lr4_crossover_filter: a bit-exact fixed-point model of the
// two cascaded biquads and gain predicts each sample, compared in order with the stream.
// Depends on lr4_pkg and the lr4_crossover_filter RTL.

module tb_lr4_crossover_filter;
  import lr4_pkg::*;

  // fraction bits of the fixed-point formats, as the arithmetic defines them
  localparam int Q_COEF  = 28;
  localparam int Q_STATE = 16;
  localparam int Q_GAIN  = 12;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 3'd7;  // index past the register list

  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 88;

  // butterworth sections at an eighth of the sample rate, Q3.28
  localparam logic [31:0] LP_B0 = 32'sd26207938;
  localparam logic [31:0] LP_B1 = 32'sd52415876;
  localparam logic [31:0] HP_B0 = 32'sd152749329;
  localparam logic [31:0] HP_B1 = -32'sd305498658;
  localparam logic [31:0] BW_A1 = -32'sd253083380;
  localparam logic [31:0] BW_A2 = 32'sd89478485;
  localparam logic [31:0] UNITY_COEF = 32'sd268435456;

  // ---------------------------------------------------------------------------
  // fixed-point predictor and queue of expected samples
  class lr4_scoreboard;
    logic [COEF_BITS-1:0]   coef_q [5];
    logic [GAIN_BITS-1:0]   gain_q;
    logic                   enable_q;
    logic signed [63:0]     s1_d1, s1_d2, s2_d1, s2_d2;
    logic [SAMPLE_BITS-1:0] expected_samples [$];
    int mismatches, checked, filtered, bypassed, muted, reg_writes;

    function new();
      for (int i = 0; i < 5; i++) coef_q[i] = '0;
      gain_q   = GAIN_UNITY;
      enable_q = 1'b0;
      clear_state();
    endfunction

    function void clear_state();
      s1_d1 = 0;
      s1_d2 = 0;
      s2_d1 = 0;
      s2_d2 = 0;
    endfunction

    function logic signed [63:0] clamp_bits(input logic signed [127:0] v, input int w);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lo = -hi - 128'sd1;
      if (v > hi) return hi[63:0];
      if (v < lo) return lo[63:0];
      return v[63:0];
    endfunction

    // exact product, round half up, drop sh bits, saturate to w bits
    function logic signed [63:0] mul_round(input logic signed [63:0] a,
                                           input logic signed [63:0] c,
                                           input int sh, input int w);
      logic signed [127:0] prod, half;
      prod = a;
      prod = prod * c;
      half = 128'sd1 <<< (sh - 1);
      prod = (prod + half) >>> sh;
      return clamp_bits(prod, w);
    endfunction

    function logic signed [63:0] sat_add(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
      logic signed [127:0] s;
      s = a;
      s = s + b;
      return clamp_bits(s, STATE_BITS);
    endfunction

    function void write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
      reg_writes++;
      case (idx)
        REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: coef_q[idx] = data;
        REG_GAIN: gain_q   = data[GAIN_BITS-1:0];
        REG_EN:   enable_q = data[0];
        default:  return;  // unmapped index leaves the state alone
      endcase
      clear_state();
    endfunction

    function logic [SAMPLE_BITS-1:0] predict_sample(input logic [SAMPLE_BITS-1:0] raw);
      logic signed [63:0]  smp, g, b0, b1, b2, na1, na2, tmp, x, y, z, res;
      logic signed [127:0] wide;
      smp = $signed(raw);
      g   = {48'd0, gain_q};
      // mute: zero out, state held
      if (gain_q == '0) begin
        muted++;
        return '0;
      end
      // bypass: gain only, state held
      if (!enable_q) begin
        bypassed++;
        res = mul_round(smp, g, Q_GAIN, SAMPLE_BITS);
        return res[SAMPLE_BITS-1:0];
      end
      filtered++;
      b0  = $signed(coef_q[0]);
      b1  = $signed(coef_q[1]);
      b2  = $signed(coef_q[2]);
      tmp = $signed(coef_q[3]);
      na1 = -tmp;
      tmp = $signed(coef_q[4]);
      na2 = -tmp;
      wide = smp;
      wide = wide <<< Q_STATE;
      x = clamp_bits(wide, STATE_BITS);
      // first section
      y = sat_add(mul_round(b0, x, Q_COEF, STATE_BITS), s1_d1);
      s1_d1 = sat_add(sat_add(mul_round(b1, x, Q_COEF, STATE_BITS),
                              mul_round(na1, y, Q_COEF, STATE_BITS)), s1_d2);
      s1_d2 = sat_add(mul_round(b2, x, Q_COEF, STATE_BITS),
                      mul_round(na2, y, Q_COEF, STATE_BITS));
      // second section
      z = sat_add(mul_round(b0, y, Q_COEF, STATE_BITS), s2_d1);
      s2_d1 = sat_add(sat_add(mul_round(b1, y, Q_COEF, STATE_BITS),
                              mul_round(na1, z, Q_COEF, STATE_BITS)), s2_d2);
      s2_d2 = sat_add(mul_round(b2, y, Q_COEF, STATE_BITS),
                      mul_round(na2, z, Q_COEF, STATE_BITS));
      res = mul_round(z, g, Q_STATE + Q_GAIN, SAMPLE_BITS);
      return res[SAMPLE_BITS-1:0];
    endfunction

    function void note_sample(input logic [SAMPLE_BITS-1:0] raw);
      expected_samples.push_back(predict_sample(raw));
    endfunction

    function void flag(input string what, input logic [SAMPLE_BITS-1:0] exp_v,
                       input logic [SAMPLE_BITS-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s: expected %0d (0x%06h) got %0d (0x%06h)", $realtime, what,
                 $signed(exp_v), exp_v, $signed(act_v), act_v);
    endfunction

    function void check_result(input logic [SAMPLE_BITS-1:0] actual);
      logic [SAMPLE_BITS-1:0] exp_v;
      checked++;
      if (expected_samples.size() == 0) begin
        flag("result with no request pending", '0, actual);
        return;
      end
      exp_v = expected_samples.pop_front();
      if (actual !== exp_v) flag("sample_out mismatch", exp_v, actual);
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [TDATA_BITS-1:0]    in_tdata;   // [23:0] sample_in
  logic                     out_tvalid;
  logic                     out_tready;
  logic [TDATA_BITS-1:0]    out_tdata;  // [23:0] sample_out
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  lr4_scoreboard sb;
  int  send_idle_pct;
  int  stall_pct;
  int  hold_left;
  int  cycle_count;
  bit  offering;

  lr4_crossover_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls plus an explicit hold-off counter
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[SAMPLE_BITS-1:0]);
  end

  // ---------------------------------------------------------------------------
  task automatic drop_valid();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one request, wait for the handshake, return at the next falling edge
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      drop_valid();
      in_tdata <= TDATA_BITS'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_BITS'(smp);
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(smp);
    @(negedge clk);
  endtask

  task automatic wait_results();
    drop_valid();
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_write(idx, data);
    cfg_we <= 1'b0;
  endtask

  // full register set; unused upper bits of gain and enable carry noise
  task automatic program_filter(input logic [31:0] b0, input logic [31:0] b1,
                                input logic [31:0] b2, input logic [31:0] a1,
                                input logic [31:0] a2, input logic [15:0] gain,
                                input logic en);
    logic [31:0] noise;
    wait_idle();
    noise = $urandom;
    cfg_write(REG_B0, b0);
    cfg_write(REG_B1, b1);
    cfg_write(REG_B2, b2);
    cfg_write(REG_A1, a1);
    cfg_write(REG_A2, a2);
    cfg_write(REG_GAIN, {noise[31:16], gain});
    cfg_write(REG_EN, {noise[31:1], en});
    if ($urandom_range(2) == 0) cfg_write(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(11))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3, 4:    return prev;  // runs of one value let the filter settle
      5, 6:    return SAMPLE_BITS'($urandom_range(512)) - SAMPLE_BITS'(256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'hffff;
      1:       return 16'd1;
      2, 3, 4: return 16'($urandom_range(8192, 2048));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] small_coef();
    return 32'(int'($urandom_range(268435456)) - 134217728);
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 81; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 81; end
      default: begin send_idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    logic [SAMPLE_BITS-1:0] last_smp;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    hold_left  = 0;
    offering   = 1'b0;
    cycle_count = 0;
    last_smp   = '0;
    sb = new();
    set_idling(3);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: bypass at unity gain
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-24'sd1);
    send_sample(24'sd1);

    // mute
    set_reg(REG_GAIN, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // largest gain saturates both ways
    set_reg(REG_GAIN, 32'h0000_ffff);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'sd1000);
    send_sample(-24'sd1);

    // half gain rounds exact halves upward
    set_reg(REG_GAIN, 32'd2048);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sd3);

    // pass-through filter
    program_filter(UNITY_COEF, '0, '0, '0, '0, GAIN_UNITY, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'sd12345);

    // low-pass impulse response; an unmapped write keeps the state, a real one clears it
    program_filter(LP_B0, LP_B1, LP_B0, BW_A1, BW_A2, GAIN_UNITY, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    set_reg(REG_SPARE, $urandom);
    send_sample('0);
    send_sample('0);
    set_reg(REG_GAIN, {16'($urandom), GAIN_UNITY});
    send_sample('0);

    // random phases over several settings and idling patterns
    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase % 4);
      case (phase)
        0: program_filter(LP_B0, LP_B1, LP_B0, BW_A1, BW_A2, GAIN_UNITY, 1'b1);
        1: program_filter(HP_B0, HP_B1, HP_B0, BW_A1, BW_A2, pick_gain(), 1'b1);
        2: program_filter($urandom, $urandom, $urandom, $urandom, $urandom, pick_gain(), 1'b0);
        3: program_filter(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 16'hffff, 1'b1);
        4: program_filter(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 16'd1, 1'b1);
        5: program_filter($urandom, $urandom, $urandom, $urandom, $urandom, pick_gain(), 1'b1);
        6: program_filter(LP_B0, LP_B1, LP_B0, BW_A1, BW_A2, '0, 1'($urandom));
        default: program_filter(small_coef(), small_coef(), small_coef(), small_coef(),
                                small_coef(), pick_gain(), 1'b1);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 0 && i == 30) hold_left = 400;
        // sender pauses until the pipeline has emptied
        if (phase == 1 && i == 40) wait_results();
        last_smp = pick_sample(last_smp);
        send_sample(last_smp);
      end
    end

    // drain
    set_idling(0);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d filtered, %0d bypassed and %0d muted samples over %0d register writes",
             sb.filtered, sb.bypassed, sb.muted, sb.reg_writes);
    $display("%0d results checked, %0d mismatches, %0d left unanswered",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
